/* src/b64_pkg.sv */
package b64_pkg;

	// Nominal line length; breaks fall only between four-character groups.
	localparam int LINE_CHARS = 76;
	localparam int LINE_LEN   = (LINE_CHARS / 4) * 4;
	localparam int LINE_W     = 7;
	localparam int JOB_CHARS  = 6;
	localparam int CNT_W      = 3;

	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [7:0] CHAR_PAD = 8'h3D;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;

	// Characters caused by one input transaction, emitted from index 0 upward.
	typedef struct packed {
		logic [JOB_CHARS-1:0][7:0] chars;
		logic [CNT_W-1:0]          cnt;
	} b64_job_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] r;
		r = 8'h00;
		case (v) inside
			[6'd0:6'd25]:  r = 8'(v) + 8'd65;
			[6'd26:6'd51]: r = 8'(v) + 8'd71;
			[6'd52:6'd61]: r = 8'(v) - 8'd4;
			6'd62:         r = 8'h2B;
			default:       r = 8'h2F;
		endcase
		return r;
	endfunction

endpackage

/* src/b64_if.sv */
interface b64_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface b64_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;

	modport source (output valid, output out_char, output last, input ready);
	modport sink   (input valid, input out_char, input last, output ready);
endinterface

/* src/b64_front.sv */
module b64_front (
	input  logic               clk,
	input  logic               arst_n,
	b64_in_if.sink             raw,
	input  logic               q_full,
	output logic               q_push,
	output b64_pkg::b64_job_t  q_job
);

	logic [15:0]                 pend_q;
	logic [1:0]                  phase_q;
	logic [b64_pkg::LINE_W-1:0]  line_q;
	logic                        accept;
	logic [23:0]                 grp;
	logic                        brk;
	logic                        has_out;

	assign raw.ready = !q_full;
	assign accept    = raw.valid && raw.ready;
	assign grp       = {pend_q, raw.data_byte};
	// The line can only fill on the last character of a group.
	assign brk = (8'(line_q) + 8'd4) >= 8'(b64_pkg::LINE_LEN);

	always_comb begin
		q_job   = '0;
		has_out = 1'b0;
		if (raw.op == b64_pkg::OP_DATA) begin
			if (phase_q[1]) begin
				has_out        = 1'b1;
				q_job.chars[0] = b64_pkg::sextet_char(grp[23:18]);
				q_job.chars[1] = b64_pkg::sextet_char(grp[17:12]);
				q_job.chars[2] = b64_pkg::sextet_char(grp[11:6]);
				q_job.chars[3] = b64_pkg::sextet_char(grp[5:0]);
				q_job.chars[4] = b64_pkg::CHAR_CR;
				q_job.chars[5] = b64_pkg::CHAR_LF;
				q_job.cnt      = brk ? 3'd6 : 3'd4;
			end
		end else begin
			if (phase_q != 2'd0) begin
				// A padded group always ends the line.
				has_out = 1'b1;
				if (phase_q == 2'd1) begin
					q_job.chars[0] = b64_pkg::sextet_char(pend_q[7:2]);
					q_job.chars[1] = b64_pkg::sextet_char({pend_q[1:0], 4'b0000});
					q_job.chars[2] = b64_pkg::CHAR_PAD;
				end else begin
					q_job.chars[0] = b64_pkg::sextet_char(pend_q[15:10]);
					q_job.chars[1] = b64_pkg::sextet_char(pend_q[9:4]);
					q_job.chars[2] = b64_pkg::sextet_char({pend_q[3:0], 2'b00});
				end
				q_job.chars[3] = b64_pkg::CHAR_PAD;
				q_job.chars[4] = b64_pkg::CHAR_CR;
				q_job.chars[5] = b64_pkg::CHAR_LF;
				q_job.cnt      = 3'd6;
			end else if (line_q != '0) begin
				has_out        = 1'b1;
				q_job.chars[0] = b64_pkg::CHAR_CR;
				q_job.chars[1] = b64_pkg::CHAR_LF;
				q_job.cnt      = 3'd2;
			end
		end
	end

	assign q_push = accept && has_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			phase_q <= '0;
			line_q  <= '0;
		end else if (accept) begin
			if (raw.op == b64_pkg::OP_FLUSH) begin
				pend_q  <= '0;
				phase_q <= '0;
				line_q  <= '0;
			end else if (phase_q[1]) begin
				pend_q  <= '0;
				phase_q <= '0;
				line_q  <= brk ? '0 : line_q + 7'd4;
			end else begin
				pend_q  <= {pend_q[7:0], raw.data_byte};
				phase_q <= phase_q + 2'd1;
			end
		end
	end

endmodule

/* src/b64_queue.sv */
module b64_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  b64_pkg::b64_job_t  push_job,
	output logic               full,
	input  logic               pop,
	output logic               nonempty,
	output b64_pkg::b64_job_t  head
);

	b64_pkg::b64_job_t slot_q [2];
	logic              wr_q;
	logic              rd_q;
	logic [1:0]        cnt_q;

	assign full     = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign head     = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* src/b64_back.sv */
module b64_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_nonempty,
	input  b64_pkg::b64_job_t  q_head,
	output logic               q_pop,
	b64_out_if.source          enc
);

	b64_pkg::b64_job_t            cur_q;
	logic [b64_pkg::CNT_W-1:0]    idx_q;
	logic                         busy_q;
	logic                         is_last;
	logic                         done;

	assign is_last      = idx_q == cur_q.cnt - 3'd1;
	assign enc.valid    = busy_q;
	assign enc.out_char = cur_q.chars[idx_q];
	assign enc.last     = is_last;
	assign done         = busy_q && enc.ready && is_last;
	// The next job is taken in the cycle the previous last character leaves.
	assign q_pop        = q_nonempty && (!busy_q || done);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && enc.ready) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

endmodule

/* src/base64_mime_encoder.sv */
// Streaming Base64 encoder with MIME line breaks. Each raw transaction with op 0 adds one
// byte; every third byte yields four alphabet characters, and CR LF follows when the line
// reaches LINE_CHARS (rounded down to a multiple of four). A transaction with op 1 pads a
// pending group with '=', closes a non-empty line with CR LF and clears all state; last
// marks the final character caused by each input transaction, and transactions that cause
// no characters produce nothing on enc. Input is taken one transaction per cycle while the
// two-entry job queue between the classifier and the emitter has room. Output runs at one
// character per cycle while enc.ready is high, so the sustained rate is set by the
// single-character output port.
module base64_mime_encoder (
	input  logic       clk,
	input  logic       arst_n,
	b64_in_if.sink     raw,
	b64_out_if.source  enc
);

	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              q_nonempty;
	b64_pkg::b64_job_t push_job;
	b64_pkg::b64_job_t head_job;

	b64_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (push_job)
	);

	b64_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head     (head_job)
	);

	b64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (head_job),
		.q_pop      (q_pop),
		.enc        (enc)
	);

endmodule

/* src/b64_checker.sv */
module b64_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       enc_valid,
	input logic       enc_ready,
	input logic [7:0] enc_char,
	input logic       enc_last
);

	// A stalled character must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		enc_valid && !enc_ready |=> enc_valid && $stable(enc_char) && $stable(enc_last))
		else $error("output changed while stalled");

	// CR is never the final character of a transaction.
	a_cr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		enc_valid && enc_char == b64_pkg::CHAR_CR |-> !enc_last)
		else $error("CR marked last");

	// A taken CR is followed at once by a final LF.
	a_cr_lf: assert property (@(posedge clk) disable iff (!arst_n)
		enc_valid && enc_ready && enc_char == b64_pkg::CHAR_CR
		|=> enc_valid && enc_char == b64_pkg::CHAR_LF && enc_last)
		else $error("CR not followed by final LF");

	// LF only ever closes a transaction's output.
	a_lf_last: assert property (@(posedge clk) disable iff (!arst_n)
		enc_valid && enc_char == b64_pkg::CHAR_LF |-> enc_last)
		else $error("LF not marked last");

endmodule

bind base64_mime_encoder b64_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.enc_valid (enc.valid),
	.enc_ready (enc.ready),
	.enc_char  (enc.out_char),
	.enc_last  (enc.last)
);
